// ===== rtl/wmc_pkg.sv =====
// Shared types and constants of the watermark manifest checker.
package wmc_pkg;

    localparam logic [31:0] MANIFEST_MAGIC   = 32'h5653_4d46;
    localparam logic [31:0] MANIFEST_VERSION = 32'd1;
    localparam int unsigned HEADER_LEN       = 12;
    localparam int unsigned ENTRY_LEN        = 2 + 8 + 8;
    localparam int unsigned CRC_LEN          = 4;
    localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;

    // 12 + 18 * (2^32 - 1) fits in 37 bits
    localparam int unsigned EXP_LEN_W        = 37;

    localparam int unsigned CFG_IDX_W        = 1;
    localparam int unsigned CFG_DATA_W       = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTE_ORDER  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHARD_LIMIT = 1'd1;
    localparam logic [CFG_DATA_W-1:0] SHARD_LIMIT_RST = 17'h1_0000;

    // header word slots (byte position / 4)
    localparam logic [1:0] HDR_MAGIC_WORD   = 2'd0;
    localparam logic [1:0] HDR_VERSION_WORD = 2'd1;

    localparam logic RESULT_ENTRY   = 1'b0;
    localparam logic RESULT_VERDICT = 1'b1;

    typedef enum logic [3:0] {
        V_OK       = 4'd0,
        V_SHORT    = 4'd1,
        V_CRC      = 4'd2,
        V_MAGIC    = 4'd3,
        V_VERSION  = 4'd4,
        V_LENGTH   = 4'd5,
        V_RANGE    = 4'd6,
        V_ORDER    = 4'd7,
        V_RELEASED = 4'd8
    } verdict_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_beat_t;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] shard_id;
        logic [63:0] applied_mark;
        logic [63:0] released_mark;
        verdict_t    verdict;
    } out_beat_t;

endpackage

// ===== rtl/watermark_manifest_checker_core.sv =====
// Top level of the watermark manifest checker: byte parser, CRC and result skid.
//
// Usage
//   s_* : one manifest byte per beat, final_byte set on the last byte.
//   m_* : results. A parsed entry (result_kind 0) for every entry that passes
//         its checks while the header and all earlier entries are still good,
//         and one verdict beat (result_kind 1) on the final byte.
//   cfg_we/cfg_index/cfg_data : byte_order (index 0), shard_limit (index 1).
//         Write only while the block is idle.
// Timing
//   One byte per clock while s_ready is high. A byte's result is registered
//   into the output slot or skid; CRC update and field gather are combinational.
//   A two-deep output (register plus skid) keeps s_ready high while one
//   result waits; s_ready drops only when both slots hold results.
// Reset
//   aresetn low clears the parse state, the output slots and sets
//   byte_order 0, shard_limit 65536. After each verdict the parse state
//   returns to its reset value, so the next byte opens a new manifest.
// Stall
//   With m_ready low, results hold in order; nothing is dropped.
module watermark_manifest_checker_core #(
    parameter int unsigned COUNTER_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  wmc_pkg::in_beat_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output wmc_pkg::out_beat_t                m_data,
    input  logic                              cfg_we,
    input  logic [wmc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wmc_pkg::*;

    localparam int unsigned CW = COUNTER_WIDTH;
    localparam int unsigned LW = (CW > EXP_LEN_W) ? CW : EXP_LEN_W;
    localparam logic [4:0]  LAST_OFF = 5'(ENTRY_LEN - 1);

    // ---------------- configuration ----------------
    logic                  byte_order_reg;
    logic [CFG_DATA_W-1:0] shard_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_order_reg  <= 1'b0;
            shard_limit_reg <= SHARD_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BYTE_ORDER:  byte_order_reg  <= cfg_data[0];
                CFG_SHARD_LIMIT: shard_limit_reg <= cfg_data;
            endcase
        end
    end

    // ---------------- helpers ----------------
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // k is the byte's place inside its field
    function automatic logic [63:0] gather(input logic [63:0] cur, input logic [7:0] b,
                                           input logic [2:0] k, input logic be);
        logic [63:0] base;
        base = (k == 3'd0) ? 64'd0 : cur;
        if (be) begin
            return {base[55:0], b};
        end
        return base | ({56'd0, b} << {k, 3'b000});
    endfunction

    // ---------------- parse state ----------------
    logic [7:0]           tail_reg [4];
    logic [7:0]           tail_next [4];
    logic [31:0]          crc_reg, crc_next;
    logic [CW-1:0]        seen_reg, seen_next;
    logic [63:0]          shift_reg, shift_next;
    logic [31:0]          total_reg, total_next;
    logic [31:0]          done_reg, done_next;
    logic [4:0]           off_reg, off_next;
    logic [15:0]          cur_shard_reg, cur_shard_next;
    logic [63:0]          cur_applied_reg, cur_applied_next;
    logic [15:0]          prev_shard_reg, prev_shard_next;
    logic                 have_prev_reg, have_prev_next;
    verdict_t             hdr_status_reg, hdr_status_next;
    verdict_t             entry_err_reg, entry_err_next;
    logic [EXP_LEN_W-1:0] exp_len_reg;

    logic [7:0]  b;
    logic        accept;
    logic        emit;
    logic        res_valid;
    out_beat_t   res;
    logic [2:0]  k;
    logic [4:0]  off_rel;
    verdict_t    ent_err;
    verdict_t    verdict;
    logic [31:0] stored_crc;

    assign b      = s_data.data_byte;
    assign accept = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < 4; i++) tail_next[i] = tail_reg[i];
        crc_next         = crc_reg;
        seen_next        = seen_reg;
        shift_next       = shift_reg;
        total_next       = total_reg;
        done_next        = done_reg;
        off_next         = off_reg;
        cur_shard_next   = cur_shard_reg;
        cur_applied_next = cur_applied_reg;
        prev_shard_next  = prev_shard_reg;
        have_prev_next   = have_prev_reg;
        hdr_status_next  = hdr_status_reg;
        entry_err_next   = entry_err_reg;
        emit             = 1'b0;
        k                = 3'd0;
        off_rel          = 5'd0;
        ent_err          = V_OK;
        verdict          = V_OK;
        stored_crc       = 32'd0;

        // CRC trails the input by four bytes
        if (seen_reg >= CW'(CRC_LEN)) crc_next = crc_byte(crc_reg, tail_reg[0]);
        tail_next[0] = tail_reg[1];
        tail_next[1] = tail_reg[2];
        tail_next[2] = tail_reg[3];
        tail_next[3] = b;

        if (seen_reg != '1) begin
            seen_next = seen_reg + CW'(1);
            if (seen_reg < CW'(HEADER_LEN)) begin
                k          = {1'b0, seen_reg[1:0]};
                shift_next = gather(shift_reg, b, k, byte_order_reg);
                if (seen_reg[1:0] == 2'd3) begin
                    case (seen_reg[3:2])
                        HDR_MAGIC_WORD: begin
                            if (shift_next[31:0] != MANIFEST_MAGIC && hdr_status_reg == V_OK)
                                hdr_status_next = V_MAGIC;
                        end
                        HDR_VERSION_WORD: begin
                            if (shift_next[31:0] != MANIFEST_VERSION && hdr_status_reg == V_OK)
                                hdr_status_next = V_VERSION;
                        end
                        default: total_next = shift_next[31:0];
                    endcase
                end
            end else if (done_reg < total_reg) begin
                off_next = (off_reg == LAST_OFF) ? 5'd0 : off_reg + 5'd1;
                if (off_reg < 5'd2)       off_rel = off_reg;
                else if (off_reg < 5'd10) off_rel = off_reg - 5'd2;
                else                      off_rel = off_reg - 5'd10;
                k          = off_rel[2:0];
                shift_next = gather(shift_reg, b, k, byte_order_reg);
                if (off_reg == 5'd1) cur_shard_next   = shift_next[15:0];
                if (off_reg == 5'd9) cur_applied_next = shift_next;
                if (off_reg == LAST_OFF) begin
                    done_next = done_reg + 32'd1;
                    if ({1'b0, cur_shard_reg} >= shard_limit_reg)
                        ent_err = V_RANGE;
                    else if (have_prev_reg && cur_shard_reg <= prev_shard_reg)
                        ent_err = V_ORDER;
                    else if (shift_next > cur_applied_reg)
                        ent_err = V_RELEASED;
                    if (ent_err != V_OK) begin
                        if (entry_err_reg == V_OK) entry_err_next = ent_err;
                    end else if (entry_err_reg == V_OK) begin
                        prev_shard_next = cur_shard_reg;
                        have_prev_next  = 1'b1;
                        emit            = (hdr_status_reg == V_OK);
                    end
                end
            end
        end

        res.result_kind   = RESULT_ENTRY;
        res.shard_id      = cur_shard_next;
        res.applied_mark  = cur_applied_next;
        res.released_mark = shift_next;
        res.verdict       = V_OK;

        if (s_data.final_byte) begin
            stored_crc = byte_order_reg ?
                {tail_next[0], tail_next[1], tail_next[2], tail_next[3]} :
                {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
            if (seen_next < CW'(HEADER_LEN + CRC_LEN))
                verdict = V_SHORT;
            else if (~crc_next != stored_crc)
                verdict = V_CRC;
            else if (hdr_status_next != V_OK)
                verdict = hdr_status_next;
            else if (seen_next == '1 ||
                     (LW'(seen_next) - LW'(CRC_LEN)) != LW'(exp_len_reg))
                verdict = V_LENGTH;
            else
                verdict = entry_err_next;

            res.result_kind   = RESULT_VERDICT;
            res.shard_id      = 16'd0;
            res.applied_mark  = 64'd0;
            res.released_mark = 64'd0;
            res.verdict       = verdict;

            // start a fresh manifest
            for (int i = 0; i < 4; i++) tail_next[i] = 8'd0;
            crc_next         = '1;
            seen_next        = '0;
            shift_next       = '0;
            total_next       = '0;
            done_next        = '0;
            off_next         = '0;
            cur_shard_next   = '0;
            cur_applied_next = '0;
            prev_shard_next  = '0;
            have_prev_next   = 1'b0;
            hdr_status_next  = V_OK;
            entry_err_next   = V_OK;
        end

        res_valid = s_data.final_byte || emit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) tail_reg[i] <= 8'd0;
            crc_reg         <= '1;
            seen_reg        <= '0;
            shift_reg       <= '0;
            total_reg       <= '0;
            done_reg        <= '0;
            off_reg         <= '0;
            cur_shard_reg   <= '0;
            cur_applied_reg <= '0;
            prev_shard_reg  <= '0;
            have_prev_reg   <= 1'b0;
            hdr_status_reg  <= V_OK;
            entry_err_reg   <= V_OK;
        end else if (accept) begin
            for (int i = 0; i < 4; i++) tail_reg[i] <= tail_next[i];
            crc_reg         <= crc_next;
            seen_reg        <= seen_next;
            shift_reg       <= shift_next;
            total_reg       <= total_next;
            done_reg        <= done_next;
            off_reg         <= off_next;
            cur_shard_reg   <= cur_shard_next;
            cur_applied_reg <= cur_applied_next;
            prev_shard_reg  <= prev_shard_next;
            have_prev_reg   <= have_prev_next;
            hdr_status_reg  <= hdr_status_next;
            entry_err_reg   <= entry_err_next;
        end
    end

    // Expected body length, registered from the entry count. The count lands
    // at byte 11, and no verdict before byte 15 reads this value.
    always_ff @(posedge aclk) begin
        exp_len_reg <= ({5'd0, total_reg} << 4) + ({5'd0, total_reg} << 1)
                     + EXP_LEN_W'(HEADER_LEN);
    end

    // ---------------- output register + skid ----------------
    logic      out_valid_reg, skid_valid_reg;
    out_beat_t out_reg, skid_reg;
    logic      push, pop;

    assign s_ready = !skid_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;
    assign push    = accept && res_valid;
    assign pop     = out_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end else begin
                out_valid_reg  <= push;
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || pop) begin
            if (skid_valid_reg) begin
                out_reg  <= skid_reg;
                skid_reg <= res;
            end else begin
                out_reg  <= res;
            end
        end else if (push) begin
            skid_reg <= res;
        end
    end

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output slot is empty");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.final_byte) |=> (seen_reg == '0 && !have_prev_reg))
        else $error("parse state not cleared after final byte");

    a_prev_after_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        have_prev_reg |-> (seen_reg >= CW'(HEADER_LEN + ENTRY_LEN)))
        else $error("entry accepted before a whole entry was seen");

    a_verdict_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.result_kind == RESULT_VERDICT) |->
        (m_data.shard_id == 16'd0 && m_data.applied_mark == 64'd0 &&
         m_data.released_mark == 64'd0))
        else $error("verdict beat carries entry payload");

endmodule
